### src/led_mode_memory_controller_top_assert.svh
// Assertion macros for the light mode controller.
// Used by the core module; expects clk_i and rst_ni in scope.
`ifndef LED_MODE_MEMORY_CONTROLLER_TOP_ASSERT_SVH
`define LED_MODE_MEMORY_CONTROLLER_TOP_ASSERT_SVH

// Check a property outside of reset.
`define LMMC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lmmc assertion failed");

// Check a property at every edge, reset included.
`define LMMC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("lmmc assertion failed");

`endif

### src/lmmc_pkg.sv
// Shared types and constants of the light mode controller.
// No dependencies; used by all modules of the block.
package lmmc_pkg;

  localparam logic [7:0] SHORT_FLAG     = 8'h80;
  localparam logic [7:0] RETAINED_RESET = 8'h87;
  localparam logic [7:0] CODE_STROBE    = 8'd251;
  localparam logic [7:0] CODE_READOUT   = 8'd252;
  localparam logic [3:0] LOW_RUN        = 4'd8;
  localparam logic [7:0] STEP_ADD       = 8'd3;
  localparam logic [2:0] COUNT_MIN      = 3'd2;
  localparam logic [2:0] COUNT_MAX      = 3'd5;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CfgModeCount   = 3'd0,
    CfgLevelOne    = 3'd1,
    CfgLevelTwo    = 3'd2,
    CfgLevelThree  = 3'd3,
    CfgLevelFour   = 3'd4,
    CfgLockTicks   = 3'd5,
    CfgBatThresh   = 3'd6,
    CfgJumperBits  = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    FuncPowerOn = 1'b0,
    FuncTick    = 1'b1
  } func_e;

  typedef struct packed {
    logic [2:0] mode_count;
    logic [7:0] level_one;
    logic [7:0] level_two;
    logic [7:0] level_three;
    logic [7:0] level_four;
    logic [7:0] lock_ticks;
    logic [7:0] battery_threshold;
    logic [1:0] jumper_bits;
  } cfg_t;

endpackage

### src/lmmc_cfg.sv
// Configuration register file of the light mode controller.
// Depends on lmmc_pkg for the register index codes and the cfg_t struct.
module lmmc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lmmc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lmmc_pkg::CfgDataW-1:0] cfg_data_i,
  output lmmc_pkg::cfg_t                cfg_o
);

  lmmc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode_count        <= 3'd5;
      cfg_q.level_one         <= 8'd13;
      cfg_q.level_two         <= 8'd50;
      cfg_q.level_three       <= 8'd255;
      cfg_q.level_four        <= 8'd252;
      cfg_q.lock_ticks        <= 8'd12;
      cfg_q.battery_threshold <= 8'd125;
      cfg_q.jumper_bits       <= 2'd0;
    end else if (cfg_we_i) begin
      unique case (lmmc_pkg::cfg_idx_e'(cfg_idx_i))
        lmmc_pkg::CfgModeCount:  cfg_q.mode_count        <= cfg_data_i[2:0];
        lmmc_pkg::CfgLevelOne:   cfg_q.level_one         <= cfg_data_i;
        lmmc_pkg::CfgLevelTwo:   cfg_q.level_two         <= cfg_data_i;
        lmmc_pkg::CfgLevelThree: cfg_q.level_three       <= cfg_data_i;
        lmmc_pkg::CfgLevelFour:  cfg_q.level_four        <= cfg_data_i;
        lmmc_pkg::CfgLockTicks:  cfg_q.lock_ticks        <= cfg_data_i;
        lmmc_pkg::CfgBatThresh:  cfg_q.battery_threshold <= cfg_data_i;
        lmmc_pkg::CfgJumperBits: cfg_q.jumper_bits       <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/lmmc_core.sv
// Input register, mode state and result register of the light mode controller.
// Depends on lmmc_pkg and the assertion macros in the block's .svh header.
`include "led_mode_memory_controller_top_assert.svh"

module lmmc_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lmmc_pkg::cfg_t cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           func_i,
  input  logic [7:0]     battery_sample_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [2:0]     mode_index_o,
  output logic [7:0]     drive_level_o,
  output logic           special_mode_o,
  output logic           store_write_o,
  output logic [7:0]     store_value_o
);

  logic       s1_valid_q;
  logic       s1_func_q;
  logic [7:0] s1_sample_q;

  logic [7:0] retained_q, retained_d;
  logic [2:0] active_q, active_d;
  logic [7:0] tick_q, tick_d;
  logic [3:0] lowcnt_q, lowcnt_d;
  logic [7:0] level_q, level_d;

  logic       out_valid_q;
  logic [2:0] out_mode_q;
  logic [7:0] out_level_q;
  logic       out_special_q;
  logic       out_write_q;
  logic [7:0] out_value_q;

  logic       adv;
  logic       take;
  logic       in_xfer;
  logic       wrote;
  logic [7:0] wval;
  logic [2:0] cnt;
  logic [6:0] raw_mode;
  logic [2:0] mode_sel;
  logic [2:0] mode_inc;
  logic [2:0] next_mode;
  logic [7:0] tick_inc;
  logic [3:0] low_inc;
  logic [7:0] table_level;

  assign adv        = !out_valid_q || out_ready_i;
  assign take       = adv && s1_valid_q;
  assign in_ready_o = !s1_valid_q || adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_func_q   <= func_i;
      s1_sample_q <= battery_sample_i;
    end
  end

  always_comb begin
    if (cfg_i.mode_count < lmmc_pkg::COUNT_MIN) begin
      cnt = lmmc_pkg::COUNT_MIN;
    end else if (cfg_i.mode_count > lmmc_pkg::COUNT_MAX) begin
      cnt = lmmc_pkg::COUNT_MAX;
    end else begin
      cnt = cfg_i.mode_count;
    end
    raw_mode = retained_q[6:0];
    if (raw_mode == 7'd0 || raw_mode >= {4'd0, cnt}) begin
      mode_sel = 3'd1;
    end else begin
      mode_sel = raw_mode[2:0];
    end
    mode_inc = mode_sel + 3'd1;
    if ((retained_q & lmmc_pkg::SHORT_FLAG) != 8'd0) begin
      next_mode = (mode_inc >= cnt) ? 3'd1 : mode_inc;
    end else if (cfg_i.jumper_bits != 2'd0) begin
      next_mode = (mode_sel == 3'd1) ? 3'd2 : 3'd1;
    end else begin
      next_mode = 3'd1;
    end
    case (mode_sel)
      3'd1:    table_level = cfg_i.level_one;
      3'd2:    table_level = cfg_i.level_two;
      3'd3:    table_level = cfg_i.level_three;
      3'd4:    table_level = cfg_i.level_four;
      default: table_level = 8'd0;
    endcase
    tick_inc = (tick_q == 8'hff) ? tick_q : tick_q + 8'd1;
    low_inc  = lowcnt_q + 4'd1;

    retained_d = retained_q;
    active_d   = active_q;
    tick_d     = tick_q;
    lowcnt_d   = lowcnt_q;
    level_d    = level_q;
    wrote      = 1'b0;
    wval       = 8'd0;

    if (lmmc_pkg::func_e'(s1_func_q) == lmmc_pkg::FuncPowerOn) begin
      active_d   = mode_sel;
      wval       = {5'd0, next_mode} | lmmc_pkg::SHORT_FLAG;
      retained_d = wval;
      wrote      = 1'b1;
      tick_d     = 8'd0;
      lowcnt_d   = 4'd0;
      level_d    = table_level;
    end else begin
      tick_d = tick_inc;
      if (tick_inc == cfg_i.lock_ticks) begin
        wval       = cfg_i.jumper_bits[1] ? 8'd1 : {5'd0, active_q};
        retained_d = wval;
        wrote      = 1'b1;
      end
      if (s1_sample_q < cfg_i.battery_threshold) begin
        lowcnt_d = low_inc;
        if (low_inc > lmmc_pkg::LOW_RUN) begin
          if (level_q != lmmc_pkg::CODE_STROBE && level_q != lmmc_pkg::CODE_READOUT) begin
            level_d = {1'b0, level_q[7:1]} + lmmc_pkg::STEP_ADD;
          end
          lowcnt_d = 4'd0;
        end
      end else begin
        lowcnt_d = 4'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retained_q <= lmmc_pkg::RETAINED_RESET;
      active_q   <= 3'd1;
      tick_q     <= 8'd0;
      lowcnt_q   <= 4'd0;
      level_q    <= 8'd0;
    end else if (take) begin
      retained_q <= retained_d;
      active_q   <= active_d;
      tick_q     <= tick_d;
      lowcnt_q   <= lowcnt_d;
      level_q    <= level_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_mode_q    <= active_d;
      out_level_q   <= level_d;
      out_special_q <= (level_d == lmmc_pkg::CODE_STROBE) ||
                       (level_d == lmmc_pkg::CODE_READOUT);
      out_write_q   <= wrote;
      out_value_q   <= wval;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mode_index_o   = out_mode_q;
  assign drive_level_o  = out_level_q;
  assign special_mode_o = out_special_q;
  assign store_write_o  = out_write_q;
  assign store_value_o  = out_value_q;

  `LMMC_ASSERT_ALWAYS(a_lowcnt_range, !rst_ni || lowcnt_q <= lmmc_pkg::LOW_RUN)
  `LMMC_ASSERT(a_no_write_zero, out_valid_q && !out_write_q |-> out_value_q == 8'd0)
  `LMMC_ASSERT(a_mode_range, out_valid_q |-> out_mode_q != 3'd0 && out_mode_q <= 3'd4)
  `LMMC_ASSERT(a_stall_blocks, s1_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
  `LMMC_ASSERT(a_poweron_clears, take && !s1_func_q |=> tick_q == 8'd0 && lowcnt_q == 4'd0)

endmodule

### src/led_mode_memory_controller_top.sv
// Top level of the light mode controller with a retained mode byte.
// Depends on lmmc_pkg, lmmc_cfg and lmmc_core.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries func_i (0 power-on,
//   1 tick) and battery_sample_i. Each transfer yields exactly one result
//   on the output channel (out_valid_o/out_ready_i): mode_index_o,
//   drive_level_o, special_mode_o, store_write_o, store_value_o.
//   From an input transfer to out_valid_o an item passes the input
//   register, then the state update and the result register.
//   Throughput is one item per cycle while the output is not stalled;
//   the mode state loop closes through the state registers.
//   Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i;
//   write only while no item is in flight.
//   Reset: configuration takes its defaults, the retained byte is 0x87,
//   the active mode 1, the counters and drive level 0; no result pending.
//   Stall: while the result waits, one more item is held in the input
//   register; then in_ready_o drops until the result transfers.
module led_mode_memory_controller_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lmmc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lmmc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [7:0]                    battery_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    mode_index_o,
  output logic [7:0]                    drive_level_o,
  output logic                          special_mode_o,
  output logic                          store_write_o,
  output logic [7:0]                    store_value_o
);

  lmmc_pkg::cfg_t cfg;

  lmmc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lmmc_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .battery_sample_i (battery_sample_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .mode_index_o     (mode_index_o),
    .drive_level_o    (drive_level_o),
    .special_mode_o   (special_mode_o),
    .store_write_o    (store_write_o),
    .store_value_o    (store_value_o)
  );

endmodule

### test/tb_led_mode_memory_controller_top.sv
// Testbench for led_mode_memory_controller_top: power-on and tick transfers under
// random idling, each result checked against a local lamp state model.
// Depends on lmmc_pkg and the RTL of the block; reads no files.
module tb_led_mode_memory_controller_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned MAX_REPORTS  = 30;

  localparam lmmc_pkg::cfg_t DEFAULT_CFG = '{
    mode_count: 3'd5, level_one: 8'd13, level_two: 8'd50, level_three: 8'd255,
    level_four: 8'd252, lock_ticks: 8'd12, battery_threshold: 8'd125, jumper_bits: 2'd0
  };

  typedef struct packed {
    logic [2:0] mode_index;
    logic [7:0] drive_level;
    logic       special_mode;
    logic       store_write;
    logic [7:0] store_value;
  } lamp_status_t;

  logic                          clk_i            = 1'b0;
  logic                          rst_ni           = 1'b0;
  logic                          cfg_we_i         = 1'b0;
  logic [lmmc_pkg::CfgIdxW-1:0]  cfg_idx_i        = '0;
  logic [lmmc_pkg::CfgDataW-1:0] cfg_data_i       = '0;
  logic                          in_valid_i       = 1'b0;
  logic                          in_ready_o;
  logic                          func_i           = 1'b0;
  logic [7:0]                    battery_sample_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i      = 1'b0;
  logic [2:0]                    mode_index_o;
  logic [7:0]                    drive_level_o;
  logic                          special_mode_o;
  logic                          store_write_o;
  logic [7:0]                    store_value_o;

  lmmc_pkg::cfg_t shadow_cfg;
  logic [7:0]     retained_byte;
  logic [2:0]     active_mode;
  logic [7:0]     tick_count;
  logic [3:0]     low_count;
  logic [7:0]     level_now;

  lamp_status_t lamp_status_q[$];

  int unsigned err_count      = 0;
  int unsigned items_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned cfg_writes     = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 11;
  int unsigned recv_stall_pct = 69;

  led_mode_memory_controller_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .battery_sample_i (battery_sample_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .mode_index_o     (mode_index_o),
    .drive_level_o    (drive_level_o),
    .special_mode_o   (special_mode_o),
    .store_write_o    (store_write_o),
    .store_value_o    (store_value_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic void reset_lamp_model();
    shadow_cfg    = DEFAULT_CFG;
    retained_byte = lmmc_pkg::RETAINED_RESET;
    active_mode   = 3'd1;
    tick_count    = '0;
    low_count     = '0;
    level_now     = '0;
  endfunction

  function automatic lamp_status_t advance_lamp_state(logic f, logic [7:0] sample);
    lamp_status_t res;
    logic [2:0]   cnt;
    logic [6:0]   m;
    logic [6:0]   nxt;
    res = '0;
    if (f == lmmc_pkg::FuncPowerOn) begin
      cnt = shadow_cfg.mode_count;
      if (cnt < lmmc_pkg::COUNT_MIN) cnt = lmmc_pkg::COUNT_MIN;
      if (cnt > lmmc_pkg::COUNT_MAX) cnt = lmmc_pkg::COUNT_MAX;
      m = retained_byte[6:0];
      if (m == 7'd0 || m >= cnt) m = 7'd1;
      if (retained_byte[7]) begin
        nxt = m + 7'd1;
        if (nxt >= cnt) nxt = 7'd1;
      end else if (shadow_cfg.jumper_bits != 2'd0) begin
        nxt = (m == 7'd1) ? 7'd2 : 7'd1;
      end else begin
        nxt = 7'd1;
      end
      active_mode     = m[2:0];
      res.store_write = 1'b1;
      res.store_value = lmmc_pkg::SHORT_FLAG | {1'b0, nxt};
      retained_byte   = res.store_value;
      tick_count      = '0;
      low_count       = '0;
      case (m)
        7'd1:    level_now = shadow_cfg.level_one;
        7'd2:    level_now = shadow_cfg.level_two;
        7'd3:    level_now = shadow_cfg.level_three;
        7'd4:    level_now = shadow_cfg.level_four;
        default: level_now = 8'd0;
      endcase
    end else begin
      if (tick_count != 8'hff) tick_count++;
      if (tick_count == shadow_cfg.lock_ticks) begin
        res.store_write = 1'b1;
        res.store_value = shadow_cfg.jumper_bits[1] ? 8'd1 : {5'd0, active_mode};
        retained_byte   = res.store_value;
      end
      if (sample < shadow_cfg.battery_threshold) begin
        low_count++;
        if (low_count > lmmc_pkg::LOW_RUN) begin
          if (level_now != lmmc_pkg::CODE_STROBE && level_now != lmmc_pkg::CODE_READOUT)
            level_now = (level_now >> 1) + lmmc_pkg::STEP_ADD;
          low_count = '0;
        end
      end else begin
        low_count = '0;
      end
    end
    res.mode_index   = active_mode;
    res.drive_level  = level_now;
    res.special_mode = (level_now == lmmc_pkg::CODE_STROBE ||
                        level_now == lmmc_pkg::CODE_READOUT);
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: got %0d, want %0d (result %0d)",
               $realtime, what, got, want, results_seen);
  endtask

  task automatic check_status(lamp_status_t want);
    if (mode_index_o !== want.mode_index)
      report_mismatch("mode_index", mode_index_o, want.mode_index);
    if (drive_level_o !== want.drive_level)
      report_mismatch("drive_level", drive_level_o, want.drive_level);
    if (special_mode_o !== want.special_mode)
      report_mismatch("special_mode", special_mode_o, want.special_mode);
    if (store_write_o !== want.store_write)
      report_mismatch("store_write", store_write_o, want.store_write);
    if (store_value_o !== want.store_value)
      report_mismatch("store_value", store_value_o, want.store_value);
  endtask

  always @(negedge clk_i) out_ready_i = ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (lamp_status_q.size() == 0) report_mismatch("result with nothing pending", 1, 0);
        else check_status(lamp_status_q.pop_front());
      end
      if (in_valid_i && in_ready_o) begin
        items_sent++;
        lamp_status_q.push_back(advance_lamp_state(func_i, battery_sample_i));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               lamp_status_q.size());
      $display("** led_mode_memory_controller_top: FAILED **");
      $finish;
    end
  end

  task automatic send_item(lmmc_pkg::func_e f, logic [7:0] sample);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    func_i           = f;
    battery_sample_i = sample;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (lamp_status_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(lmmc_pkg::cfg_idx_e idx, logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      lmmc_pkg::CfgModeCount:  shadow_cfg.mode_count        = value[2:0];
      lmmc_pkg::CfgLevelOne:   shadow_cfg.level_one         = value;
      lmmc_pkg::CfgLevelTwo:   shadow_cfg.level_two         = value;
      lmmc_pkg::CfgLevelThree: shadow_cfg.level_three       = value;
      lmmc_pkg::CfgLevelFour:  shadow_cfg.level_four        = value;
      lmmc_pkg::CfgLockTicks:  shadow_cfg.lock_ticks        = value;
      lmmc_pkg::CfgBatThresh:  shadow_cfg.battery_threshold = value;
      lmmc_pkg::CfgJumperBits: shadow_cfg.jumper_bits       = value[1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic apply_config(lmmc_pkg::cfg_t c);
    wait_drained();
    write_reg(lmmc_pkg::CfgModeCount,  {5'd0, c.mode_count});
    write_reg(lmmc_pkg::CfgLevelOne,   c.level_one);
    write_reg(lmmc_pkg::CfgLevelTwo,   c.level_two);
    write_reg(lmmc_pkg::CfgLevelThree, c.level_three);
    write_reg(lmmc_pkg::CfgLevelFour,  c.level_four);
    write_reg(lmmc_pkg::CfgLockTicks,  c.lock_ticks);
    write_reg(lmmc_pkg::CfgBatThresh,  c.battery_threshold);
    write_reg(lmmc_pkg::CfgJumperBits, {6'd0, c.jumper_bits});
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return lmmc_pkg::CODE_STROBE;
      1:       return lmmc_pkg::CODE_READOUT;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic lmmc_pkg::cfg_t random_cfg(int unsigned lock_lo, int unsigned lock_hi);
    lmmc_pkg::cfg_t c;
    c.mode_count        = 3'($urandom_range(0, 7));
    c.level_one         = pick_level();
    c.level_two         = pick_level();
    c.level_three       = pick_level();
    c.level_four        = pick_level();
    c.lock_ticks        = 8'($urandom_range(lock_lo, lock_hi));
    c.battery_threshold = 8'($urandom_range(0, 255));
    c.jumper_bits       = 2'($urandom_range(0, 3));
    return c;
  endfunction

  // style 0: low run, 1: healthy battery, 2: mostly low
  function automatic logic [7:0] pick_sample(int unsigned style);
    logic [7:0] thr;
    thr = shadow_cfg.battery_threshold;
    if (thr == 8'd0) return 8'($urandom_range(0, 255));
    if (style == 1 || (style == 2 && $urandom_range(0, 4) == 0))
      return 8'($urandom_range(thr, 255));
    return 8'($urandom_range(0, thr - 1));
  endfunction

  task automatic run_sessions(int unsigned n_items, int unsigned max_ticks);
    int unsigned sent;
    int unsigned n_ticks;
    int unsigned style;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 15) begin
        send_item(lmmc_pkg::func_e'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        sent++;
      end else begin
        send_item(lmmc_pkg::FuncPowerOn, 8'($urandom_range(0, 255)));
        n_ticks = $urandom_range(0, max_ticks);
        style   = $urandom_range(0, 2);
        repeat (n_ticks) send_item(lmmc_pkg::FuncTick, pick_sample(style));
        sent += n_ticks + 1;
      end
    end
  endtask

  task automatic test_tick_before_power_on();
    repeat (9) send_item(lmmc_pkg::FuncTick, 8'd0);
  endtask

  task automatic test_mode_cycle();
    repeat (4) send_item(lmmc_pkg::FuncPowerOn, 8'hff);
  endtask

  task automatic test_lock_and_jumpers();
    for (int j = 0; j < 4; j++) begin
      wait_drained();
      write_reg(lmmc_pkg::CfgLockTicks, 8'd2);
      write_reg(lmmc_pkg::CfgJumperBits, 8'(j));
      repeat (2) send_item(lmmc_pkg::FuncTick, 8'hff);
      send_item(lmmc_pkg::FuncPowerOn, 8'h00);
    end
  endtask

  task automatic test_random_defaults();
    lmmc_pkg::cfg_t c;
    apply_config(DEFAULT_CFG);
    run_sessions(150, 16);
    c = random_cfg(1, 20);
    apply_config(c);
    run_sessions(100, c.lock_ticks + 6);
  endtask

  task automatic test_random_extremes();
    apply_config('{mode_count: 3'd7, level_one: lmmc_pkg::CODE_STROBE,
                   level_two: lmmc_pkg::CODE_READOUT,
                   level_three: 8'd255, level_four: 8'd0, lock_ticks: 8'd255,
                   battery_threshold: 8'd255, jumper_bits: 2'd3});
    send_item(lmmc_pkg::FuncPowerOn, 8'h00);
    repeat (262) send_item(lmmc_pkg::FuncTick, pick_sample(2));
    run_sessions(100, 40);
    apply_config('{mode_count: 3'd0, level_one: 8'd0, level_two: 8'd255,
                   level_three: lmmc_pkg::CODE_STROBE, level_four: 8'd1, lock_ticks: 8'd0,
                   battery_threshold: 8'd0, jumper_bits: 2'd1});
    run_sessions(100, 12);
    apply_config('{mode_count: 3'd1, level_one: 8'd255, level_two: 8'd0,
                   level_three: 8'd1, level_four: lmmc_pkg::CODE_READOUT, lock_ticks: 8'd1,
                   battery_threshold: 8'd128, jumper_bits: 2'd2});
    run_sessions(100, 12);
  endtask

  task automatic test_random_no_idle();
    lmmc_pkg::cfg_t c;
    repeat (3) begin
      c = random_cfg(1, 20);
      apply_config(c);
      run_sessions(80, c.lock_ticks + 6);
    end
  endtask

  initial begin
    reset_lamp_model();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct  = 11;
    recv_stall_pct = 69;
    test_tick_before_power_on();
    test_mode_cycle();
    test_lock_and_jumpers();
    test_random_defaults();

    send_idle_pct  = 69;
    recv_stall_pct = 11;
    test_random_extremes();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_no_idle();

    wait_drained();
    $display("covered %0d transfers in, %0d results checked, %0d register writes",
             items_sent, results_seen, cfg_writes);
    $display("mode counts below, inside and above range, lock counts 0 to 255, three idle mixes");
    if (err_count == 0) begin
      $display("** led_mode_memory_controller_top: PASSED **");
    end else begin
      $display("** led_mode_memory_controller_top: FAILED **");
    end
    $finish;
  end

endmodule

### led_mode_memory_controller_top.f
+incdir+src
src/lmmc_pkg.sv
src/lmmc_cfg.sv
src/lmmc_core.sv
src/led_mode_memory_controller_top.sv
test/tb_led_mode_memory_controller_top.sv
